// ===== design/nais_pkg.sv =====
// Shared types, constants and decode helpers for the NDP access instruction sequencer.
// Used by every module of the block; depends on nothing.
package nais_pkg;

	localparam int ProgramDepth = 1024;
	localparam int PcW = $clog2(ProgramDepth);
	localparam int SlotCount = 16;
	localparam int SlotIdxW = $clog2(SlotCount);
	localparam int SlotCntW = $clog2(SlotCount + 1);
	localparam int MaxUnits = 32;
	localparam int UnitIdxW = $clog2(MaxUnits);
	localparam int MaxCh = 15;
	localparam int MaxPch = 7;
	localparam int ProdW = 7;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_CTRL = 2'd1;
	localparam logic [1:0] OP_BUF = 2'd2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_BAR = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [3:0] IOP_BARRIER = 4'd3;
	localparam logic [3:0] IOP_END = 4'd15;

	localparam logic [2:0] CFG_NDP_ROW = 3'd0;
	localparam logic [2:0] CFG_START_BG = 3'd1;
	localparam logic [2:0] CFG_START_BK = 3'd2;
	localparam logic [2:0] CFG_CH_COUNT = 3'd3;
	localparam logic [2:0] CFG_PCH_COUNT = 3'd4;

	localparam logic [63:0] CTRL_START = 64'd1;

	typedef struct packed {
		logic [17:0] ndp_row;
		logic [2:0] start_bankgroup;
		logic [1:0] start_bank;
		logic [3:0] channel_count;
		logic [2:0] pch_count;
	} cfg_t;

	typedef struct packed {
		logic [3:0] op;
		logic [6:0] size;
		logic [2:0] ch;
		logic [1:0] pch;
		logic [2:0] bg;
		logic [1:0] bk;
		logic [17:0] row;
		logic [6:0] col;
		logic [2:0] id;
	} prog_entry_t;

	typedef struct packed {
		logic [6:0] size;
		logic [6:0] cnt;
		logic [2:0] ch;
		logic [1:0] pch;
		logic [2:0] bg;
		logic [1:0] bk;
		logic [17:0] row;
		logic [6:0] col;
		logic [2:0] id;
	} slot_t;

	typedef struct packed {
		logic found;
		logic [2:0] ch;
		logic [1:0] pch;
		logic [UnitIdxW-1:0] idx;
	} pick_t;

	function automatic prog_entry_t decode_word(input logic [63:0] w);
		prog_entry_t e;
		e.op = w[63:60];
		e.size = w[59:53];
		e.ch = w[52:50];
		e.pch = w[49:48];
		e.bg = w[47:45];
		e.bk = w[44:43];
		e.row = w[42:25];
		e.col = w[24:18];
		e.id = w[17:15];
		return e;
	endfunction

endpackage

// ===== design/nais_prog_store.sv =====
// Program store: one write port and one registered read port with write bypass.
// Depends on nais_pkg for the entry type and depth.
module nais_prog_store (
	input logic clk,
	input logic we,
	input logic [nais_pkg::PcW-1:0] waddr,
	input nais_pkg::prog_entry_t wdata,
	input logic [nais_pkg::PcW-1:0] raddr,
	output nais_pkg::prog_entry_t rdata
);

	nais_pkg::prog_entry_t mem [nais_pkg::ProgramDepth];
	nais_pkg::prog_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && waddr == raddr) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/nais_start_pick.sv =====
// Finds the first unit, in channel-major order, whose start write is still pending.
// Depends on nais_pkg for the configuration and result types.
module nais_start_pick (
	input nais_pkg::cfg_t cfg,
	input logic [nais_pkg::MaxUnits-1:0] issued,
	output nais_pkg::pick_t pick
);

	logic [nais_pkg::ProdW-1:0] idx_v;

	always_comb begin
		pick = '0;
		idx_v = '0;
		for (int c = nais_pkg::MaxCh - 1; c >= 0; c--) begin
			for (int p = nais_pkg::MaxPch - 1; p >= 0; p--) begin
				idx_v = nais_pkg::ProdW'(c) * nais_pkg::ProdW'(cfg.pch_count)
					+ nais_pkg::ProdW'(p);
				if (4'(c) < cfg.channel_count && 3'(p) < cfg.pch_count
					&& idx_v < nais_pkg::ProdW'(nais_pkg::MaxUnits)
					&& !issued[idx_v[nais_pkg::UnitIdxW-1:0]]) begin
					pick.found = 1'b1;
					pick.ch = 3'(c);
					pick.pch = 2'(p);
					pick.idx = idx_v[nais_pkg::UnitIdxW-1:0];
				end
			end
		end
	end

endmodule

// ===== design/ndp_access_instruction_sequencer.sv =====
// Top level of the NDP access instruction sequencer: input register, sequencing logic,
// slot table and result register. Depends on nais_pkg, nais_prog_store, nais_start_pick.
//
// Usage: an item (opcode, data_word, start_mask, buffer_column, word_index, mc_accept,
// queues_empty) is taken at a rising edge where start is high and busy is low. Busy
// stays low, so one item can be taken in every cycle. Each item produces exactly one
// result, shown on the req_* ports, busy_res and run_status for one cycle with done
// high, after the item has passed the input register and the result register. The
// receiver cannot stall, so results simply follow the items in order at one per cycle.
// A tick item offers at most one request; a start control write arms an idle unit, and
// buffer writes load the program store, whose single read port prefetches the entry at
// the program counter for the next item. The user must write the configuration port
// (cfg_we, cfg_index, cfg_data) only while no item is in flight; the block does not
// enforce this. Reset clears the sequencing state and loads the default configuration;
// the program store and slot table hold nothing meaningful until written.
module ndp_access_instruction_sequencer (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [17:0] cfg_data,
	input logic [1:0] opcode,
	input logic [63:0] data_word,
	input logic [31:0] start_mask,
	input logic [6:0] buffer_column,
	input logic [2:0] word_index,
	input logic mc_accept,
	input logic queues_empty,
	output logic req_valid,
	output logic req_is_start,
	output logic [2:0] req_channel,
	output logic [1:0] req_pseudochannel,
	output logic [2:0] req_bankgroup,
	output logic [1:0] req_bank,
	output logic [17:0] req_row,
	output logic [6:0] req_column,
	output logic [2:0] req_tag,
	output logic busy_res,
	output logic [1:0] run_status
);

	nais_pkg::cfg_t cfg_q;

	logic valid_s1;
	logic [1:0] opcode_s1;
	logic [63:0] data_word_s1;
	logic [31:0] start_mask_s1;
	logic [6:0] buffer_column_s1;
	logic [2:0] word_index_s1;
	logic mc_accept_s1;
	logic queues_empty_s1;

	nais_pkg::slot_t slot_q [nais_pkg::SlotCount];
	nais_pkg::slot_t slot_d [nais_pkg::SlotCount];
	logic [nais_pkg::SlotCntW-1:0] count_q, count_d;
	logic [nais_pkg::SlotCntW-1:0] sp_q, sp_d;
	logic [nais_pkg::PcW-1:0] pc_q, pc_d;
	logic [1:0] status_q, status_d;
	logic on_q, on_d;
	logic wait_q, wait_d;
	logic sent_q, sent_d;
	logic [nais_pkg::MaxUnits-1:0] issued_q, issued_d;

	logic done_q;
	logic req_valid_q, req_valid_d;
	logic req_is_start_q, req_is_start_d;
	logic [2:0] req_channel_q, req_channel_d;
	logic [1:0] req_pseudochannel_q, req_pseudochannel_d;
	logic [2:0] req_bankgroup_q, req_bankgroup_d;
	logic [1:0] req_bank_q, req_bank_d;
	logic [17:0] req_row_q, req_row_d;
	logic [6:0] req_column_q, req_column_d;
	logic [2:0] req_tag_q, req_tag_d;
	logic busy_res_q;
	logic [1:0] run_status_q;

	nais_pkg::pick_t pick;
	nais_pkg::prog_entry_t fetch_entry;
	logic store_we;
	logic [nais_pkg::PcW-1:0] store_waddr;
	nais_pkg::slot_t cur;
	logic [nais_pkg::SlotCntW-1:0] cnt_v, sp_v;
	logic [nais_pkg::ProdW-1:0] unit_lim;

	nais_start_pick u_pick (
		.cfg(cfg_q),
		.issued(issued_q),
		.pick(pick)
	);

	assign store_we = valid_s1 && opcode_s1 == nais_pkg::OP_BUF;
	assign store_waddr = nais_pkg::PcW'({buffer_column_s1, word_index_s1});

	nais_prog_store u_store (
		.clk(clk),
		.we(store_we),
		.waddr(store_waddr),
		.wdata(nais_pkg::decode_word(data_word_s1)),
		.raddr(pc_d),
		.rdata(fetch_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ndp_row <= 18'h3FFFF;
			cfg_q.start_bankgroup <= 3'd5;
			cfg_q.start_bank <= 2'd3;
			cfg_q.channel_count <= 4'd8;
			cfg_q.pch_count <= 3'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				nais_pkg::CFG_NDP_ROW: cfg_q.ndp_row <= cfg_data;
				nais_pkg::CFG_START_BG: cfg_q.start_bankgroup <= cfg_data[2:0];
				nais_pkg::CFG_START_BK: cfg_q.start_bank <= cfg_data[1:0];
				nais_pkg::CFG_CH_COUNT: cfg_q.channel_count <= cfg_data[3:0];
				nais_pkg::CFG_PCH_COUNT: cfg_q.pch_count <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		opcode_s1 <= opcode;
		data_word_s1 <= data_word;
		start_mask_s1 <= start_mask;
		buffer_column_s1 <= buffer_column;
		word_index_s1 <= word_index;
		mc_accept_s1 <= mc_accept;
		queues_empty_s1 <= queues_empty;
	end

	assign unit_lim = nais_pkg::ProdW'(cfg_q.channel_count)
		* nais_pkg::ProdW'(cfg_q.pch_count);

	always_comb begin
		slot_d = slot_q;
		count_d = count_q;
		sp_d = sp_q;
		pc_d = pc_q;
		status_d = status_q;
		on_d = on_q;
		wait_d = wait_q;
		sent_d = sent_q;
		issued_d = issued_q;
		req_valid_d = 1'b0;
		req_is_start_d = 1'b0;
		req_channel_d = '0;
		req_pseudochannel_d = '0;
		req_bankgroup_d = '0;
		req_bank_d = '0;
		req_row_d = '0;
		req_column_d = '0;
		req_tag_d = '0;
		cnt_v = count_q;
		sp_v = sp_q;
		cur = slot_q[0];
		if (valid_s1) begin
			case (opcode_s1)
				nais_pkg::OP_TICK: begin
					if (on_q) begin
						if (!sent_q) begin
							if (pick.found) begin
								req_valid_d = 1'b1;
								req_is_start_d = 1'b1;
								req_channel_d = pick.ch;
								req_pseudochannel_d = pick.pch;
								req_bankgroup_d = cfg_q.start_bankgroup;
								req_bank_d = cfg_q.start_bank;
								req_row_d = cfg_q.ndp_row;
								if (mc_accept_s1) begin
									issued_d[pick.idx] = 1'b1;
								end
							end else begin
								sent_d = 1'b1;
								status_d = nais_pkg::ST_RUN;
								pc_d = '0;
								sp_d = '0;
							end
						end else begin
							if (status_q != nais_pkg::ST_IDLE && count_q != '0) begin
								if (sp_v >= cnt_v) begin
									sp_v = '0;
								end
								cur = slot_q[sp_v[nais_pkg::SlotIdxW-1:0]];
								req_valid_d = 1'b1;
								req_channel_d = cur.ch;
								req_pseudochannel_d = cur.pch;
								req_bankgroup_d = cur.bg;
								req_bank_d = cur.bk;
								req_row_d = cur.row;
								req_column_d = cur.col;
								req_tag_d = cur.id;
								if (mc_accept_s1) begin
									if (cur.cnt == cur.size) begin
										for (int k = 0; k < nais_pkg::SlotCount - 1; k++) begin
											if (nais_pkg::SlotCntW'(k) >= sp_v
												&& nais_pkg::SlotCntW'(k + 1) < count_q) begin
												slot_d[k] = slot_q[k + 1];
											end
										end
										cnt_v = cnt_v - 1'b1;
									end else begin
										slot_d[sp_v[nais_pkg::SlotIdxW-1:0]].cnt = cur.cnt + 7'd1;
										slot_d[sp_v[nais_pkg::SlotIdxW-1:0]].col = cur.col + 7'd1;
										sp_v = sp_v + 1'b1;
									end
								end
							end
							case (status_q)
								nais_pkg::ST_RUN: begin
									if (cnt_v < nais_pkg::SlotCntW'(nais_pkg::SlotCount)) begin
										if (fetch_entry.op == nais_pkg::IOP_BARRIER) begin
											status_d = nais_pkg::ST_BAR;
										end else if (fetch_entry.op == nais_pkg::IOP_END) begin
											status_d = nais_pkg::ST_DONE;
										end else begin
											slot_d[cnt_v[nais_pkg::SlotIdxW-1:0]] = '{
												size: fetch_entry.size, cnt: 7'd0,
												ch: fetch_entry.ch, pch: fetch_entry.pch,
												bg: fetch_entry.bg, bk: fetch_entry.bk,
												row: fetch_entry.row, col: fetch_entry.col,
												id: fetch_entry.id};
											cnt_v = cnt_v + 1'b1;
										end
										pc_d = pc_q + 1'b1;
									end
								end
								nais_pkg::ST_BAR: begin
									if (queues_empty_s1 && cnt_v == '0) begin
										status_d = nais_pkg::ST_RUN;
									end
								end
								nais_pkg::ST_DONE: begin
									if (queues_empty_s1 && cnt_v == '0) begin
										status_d = nais_pkg::ST_IDLE;
										on_d = 1'b0;
									end
								end
								default: ;
							endcase
							sp_d = sp_v;
							count_d = cnt_v;
						end
					end
					if (wait_q && queues_empty_s1) begin
						wait_d = 1'b0;
						on_d = 1'b1;
					end
				end
				nais_pkg::OP_CTRL: begin
					if (data_word_s1 == nais_pkg::CTRL_START && !(wait_q || on_q)) begin
						wait_d = 1'b1;
						on_d = 1'b0;
						sent_d = 1'b0;
						for (int i = 0; i < nais_pkg::MaxUnits; i++) begin
							if (nais_pkg::ProdW'(i) < unit_lim && start_mask_s1[i]) begin
								issued_d[i] = 1'b0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sp_q <= '0;
			pc_q <= '0;
			status_q <= nais_pkg::ST_IDLE;
			on_q <= 1'b0;
			wait_q <= 1'b0;
			sent_q <= 1'b0;
			issued_q <= '0;
			done_q <= 1'b0;
		end else begin
			count_q <= count_d;
			sp_q <= sp_d;
			pc_q <= pc_d;
			status_q <= status_d;
			on_q <= on_d;
			wait_q <= wait_d;
			sent_q <= sent_d;
			issued_q <= issued_d;
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
		req_valid_q <= req_valid_d;
		req_is_start_q <= req_is_start_d;
		req_channel_q <= req_channel_d;
		req_pseudochannel_q <= req_pseudochannel_d;
		req_bankgroup_q <= req_bankgroup_d;
		req_bank_q <= req_bank_d;
		req_row_q <= req_row_d;
		req_column_q <= req_column_d;
		req_tag_q <= req_tag_d;
		busy_res_q <= wait_d || on_d;
		run_status_q <= status_d;
	end

	assign busy = 1'b0;
	assign done = done_q;
	assign req_valid = req_valid_q;
	assign req_is_start = req_is_start_q;
	assign req_channel = req_channel_q;
	assign req_pseudochannel = req_pseudochannel_q;
	assign req_bankgroup = req_bankgroup_q;
	assign req_bank = req_bank_q;
	assign req_row = req_row_q;
	assign req_column = req_column_q;
	assign req_tag = req_tag_q;
	assign busy_res = busy_res_q;
	assign run_status = run_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nais_pkg::SlotCntW'(nais_pkg::SlotCount))
		else $error("slot table count exceeds its depth");

	a_wait_on_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wait_q && on_q))
		else $error("unit both armed and running");

	a_status_on: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != nais_pkg::ST_IDLE |-> on_q)
		else $error("run status active while unit is off");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("item produced no result");

	a_req_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> done)
		else $error("request offered outside a result");

endmodule

// ===== tb/sv/tb_ndp_access_instruction_sequencer.sv =====
// Testbench for ndp_access_instruction_sequencer: loads short programs, arms the unit and
// ticks it to completion, checking every request and status against a built-in predictor.
// Depends on nais_pkg and the sequencer RTL.
module tb_ndp_access_instruction_sequencer;

	localparam logic [1:0] OpUnused = 2'd3;

	typedef struct packed {
		logic valid;
		logic is_start;
		logic [2:0] ch;
		logic [1:0] pch;
		logic [2:0] bg;
		logic [1:0] bk;
		logic [17:0] row;
		logic [6:0] col;
		logic [2:0] tag;
		logic busy;
		logic [1:0] status;
	} req_result_t;

	class req_scoreboard;
		nais_pkg::cfg_t cfg;
		nais_pkg::prog_entry_t prog[nais_pkg::ProgramDepth];
		nais_pkg::slot_t slots[nais_pkg::SlotCount];
		int nslots, sp, pc;
		logic [1:0] st;
		bit unit_on, waiting, sent;
		logic [31:0] issued;
		req_result_t exp_q[$];
		int errors;

		function new();
			cfg = '{ndp_row: 18'h3FFFF, start_bankgroup: 3'd5, start_bank: 2'd3,
				channel_count: 4'd8, pch_count: 3'd2};
			nslots = 0; sp = 0; pc = 0; st = nais_pkg::ST_IDLE;
			unit_on = 0; waiting = 0; sent = 0; issued = '0; errors = 0;
		endfunction

		function void set_cfg(logic [2:0] idx, logic [17:0] d);
			case (idx)
				nais_pkg::CFG_NDP_ROW: cfg.ndp_row = d;
				nais_pkg::CFG_START_BG: cfg.start_bankgroup = d[2:0];
				nais_pkg::CFG_START_BK: cfg.start_bank = d[1:0];
				nais_pkg::CFG_CH_COUNT: cfg.channel_count = d[3:0];
				nais_pkg::CFG_PCH_COUNT: cfg.pch_count = d[2:0];
				default: ;
			endcase
		endfunction

		function bit armed();
			return waiting || unit_on;
		endfunction

		function void start_writes(logic acc, inout req_result_t r);
			int idx;
			for (int c = 0; c < cfg.channel_count; c++) begin
				for (int p = 0; p < cfg.pch_count; p++) begin
					idx = c * cfg.pch_count + p;
					if (idx < nais_pkg::MaxUnits && !issued[idx]) begin
						r.valid = 1; r.is_start = 1;
						r.ch = c[2:0]; r.pch = p[1:0];
						r.bg = cfg.start_bankgroup; r.bk = cfg.start_bank;
						r.row = cfg.ndp_row;
						if (acc) issued[idx] = 1'b1;
						return;
					end
				end
			end
			sent = 1; st = nais_pkg::ST_RUN; pc = 0; sp = 0;
		endfunction

		function void run_slots(logic acc, logic qe, inout req_result_t r);
			nais_pkg::prog_entry_t e;
			if (st != nais_pkg::ST_IDLE && nslots != 0) begin
				if (sp >= nslots) sp = 0;
				r.valid = 1; r.is_start = 0;
				r.ch = slots[sp].ch; r.pch = slots[sp].pch;
				r.bg = slots[sp].bg; r.bk = slots[sp].bk;
				r.row = slots[sp].row; r.col = slots[sp].col; r.tag = slots[sp].id;
				if (acc) begin
					if (slots[sp].cnt == slots[sp].size) begin
						for (int k = sp; k + 1 < nslots; k++) slots[k] = slots[k + 1];
						nslots--;
					end else begin
						slots[sp].cnt = slots[sp].cnt + 7'd1;
						slots[sp].col = slots[sp].col + 7'd1;
						sp++;
					end
				end
			end
			if (st == nais_pkg::ST_RUN) begin
				if (nslots < nais_pkg::SlotCount) begin
					e = prog[pc];
					if (e.op == nais_pkg::IOP_BARRIER) st = nais_pkg::ST_BAR;
					else if (e.op == nais_pkg::IOP_END) st = nais_pkg::ST_DONE;
					else begin
						slots[nslots] = '{size: e.size, cnt: 7'd0, ch: e.ch, pch: e.pch,
							bg: e.bg, bk: e.bk, row: e.row, col: e.col, id: e.id};
						nslots++;
					end
					pc = (pc + 1) % nais_pkg::ProgramDepth;
				end
			end else if (st == nais_pkg::ST_BAR) begin
				if (qe && nslots == 0) st = nais_pkg::ST_RUN;
			end else if (st == nais_pkg::ST_DONE) begin
				if (qe && nslots == 0) begin
					st = nais_pkg::ST_IDLE; unit_on = 0;
				end
			end
		endfunction

		function void note_item(logic [1:0] op, logic [63:0] dw, logic [31:0] mask,
				logic [6:0] bcol, logic [2:0] widx, logic acc, logic qe);
			req_result_t r;
			int lim;
			r = '0;
			if (op == nais_pkg::OP_TICK) begin
				if (unit_on) begin
					if (!sent) start_writes(acc, r);
					else run_slots(acc, qe, r);
				end
				if (waiting && qe) begin
					waiting = 0; unit_on = 1;
				end
			end else if (op == nais_pkg::OP_CTRL) begin
				if (dw == nais_pkg::CTRL_START && !armed()) begin
					lim = cfg.channel_count * cfg.pch_count;
					if (lim > nais_pkg::MaxUnits) lim = nais_pkg::MaxUnits;
					waiting = 1; unit_on = 0; sent = 0;
					for (int i = 0; i < lim; i++) if (mask[i]) issued[i] = 1'b0;
				end
			end else if (op == nais_pkg::OP_BUF) begin
				prog[{bcol, widx}] = '{op: dw[63:60], size: dw[59:53], ch: dw[52:50],
					pch: dw[49:48], bg: dw[47:45], bk: dw[44:43], row: dw[42:25],
					col: dw[24:18], id: dw[17:15]};
			end
			r.busy = armed();
			r.status = st;
			exp_q = {exp_q, r};
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(req_result_t got);
			req_result_t w;
			if (exp_q.size() == 0) begin
				report("result with no expected item");
				return;
			end
			w = exp_q.pop_front();
			if (got.valid !== w.valid) report($sformatf("req_valid %0d/%0d", got.valid, w.valid));
			if (got.is_start !== w.is_start)
				report($sformatf("req_is_start %0d/%0d", got.is_start, w.is_start));
			if (got.ch !== w.ch) report($sformatf("req_channel %0d/%0d", got.ch, w.ch));
			if (got.pch !== w.pch) report($sformatf("req_pseudochannel %0d/%0d", got.pch, w.pch));
			if (got.bg !== w.bg) report($sformatf("req_bankgroup %0d/%0d", got.bg, w.bg));
			if (got.bk !== w.bk) report($sformatf("req_bank %0d/%0d", got.bk, w.bk));
			if (got.row !== w.row) report($sformatf("req_row %0h/%0h", got.row, w.row));
			if (got.col !== w.col) report($sformatf("req_column %0d/%0d", got.col, w.col));
			if (got.tag !== w.tag) report($sformatf("req_tag %0d/%0d", got.tag, w.tag));
			if (got.busy !== w.busy) report($sformatf("busy_res %0d/%0d", got.busy, w.busy));
			if (got.status !== w.status)
				report($sformatf("run_status %0d/%0d", got.status, w.status));
		endtask
	endclass

	logic clk, arst_n, start, busy, done, cfg_we;
	logic [2:0] cfg_index;
	logic [17:0] cfg_data;
	logic [1:0] opcode;
	logic [63:0] data_word;
	logic [31:0] start_mask;
	logic [6:0] buffer_column;
	logic [2:0] word_index;
	logic mc_accept, queues_empty;
	logic req_valid, req_is_start, busy_res;
	logic [2:0] req_channel, req_bankgroup, req_tag;
	logic [1:0] req_pseudochannel, req_bank, run_status;
	logic [17:0] req_row;
	logic [6:0] req_column;

	req_scoreboard sb = new();
	int n_items = 0;
	int cycles = 0;

	ndp_access_instruction_sequencer u_top (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 900000) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{req_valid, req_is_start, req_channel, req_pseudochannel,
				req_bankgroup, req_bank, req_row, req_column, req_tag, busy_res, run_status});
	end

	task automatic send_item(logic [1:0] op, logic [63:0] dw, logic [31:0] mask,
			logic [6:0] bcol, logic [2:0] widx, logic acc, logic qe);
		int gap_pct;
		start <= 1; opcode <= op; data_word <= dw; start_mask <= mask;
		buffer_column <= bcol; word_index <= widx; mc_accept <= acc; queues_empty <= qe;
		do @(posedge clk); while (busy);
		sb.note_item(op, dw, mask, bcol, widx, acc, qe);
		n_items++;
		gap_pct = n_items < 220 ? 28 : (n_items < 440 ? 81 : 0);
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 0;
		while (sb.exp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [17:0] d);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_cfg(idx, d);
	endtask

	task automatic write_all_regs(logic [17:0] row, logic [2:0] bg, logic [1:0] bk,
			logic [3:0] ch, logic [2:0] pch);
		wait_idle();
		write_reg(nais_pkg::CFG_NDP_ROW, row);
		write_reg(nais_pkg::CFG_START_BG, {15'd0, bg});
		write_reg(nais_pkg::CFG_START_BK, {16'd0, bk});
		write_reg(nais_pkg::CFG_CH_COUNT, {14'd0, ch});
		write_reg(nais_pkg::CFG_PCH_COUNT, {15'd0, pch});
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Loads entries 0..len-1 with accesses and barriers, an end entry at len, then starts
	// the unit and ticks it, mixing in other items, until it idles or the guard runs out.
	task automatic run_program(int len);
		logic [63:0] w;
		logic [3:0] iop;
		int guard, idx, pick;
		for (int i = 0; i <= len; i++) begin
			w = rand_word();
			if (i == len) iop = nais_pkg::IOP_END;
			else if ($urandom_range(0, 5) == 0) iop = nais_pkg::IOP_BARRIER;
			else begin
				do iop = 4'($urandom_range(0, 15));
				while (iop == nais_pkg::IOP_BARRIER || iop == nais_pkg::IOP_END);
			end
			w[63:60] = iop;
			if ($urandom_range(0, 9) != 0) w[59:53] = 7'($urandom_range(0, 2));
			send_item(nais_pkg::OP_BUF, w, $urandom(), 7'(i / 8), 3'(i % 8),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		send_item(nais_pkg::OP_CTRL, nais_pkg::CTRL_START,
			$urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom(),
			7'($urandom()), 3'($urandom()), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		guard = 0;
		while (sb.armed() && guard < 5000) begin
			guard++;
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				send_item(nais_pkg::OP_TICK, rand_word(), $urandom(), 7'($urandom()),
					3'($urandom()), $urandom_range(0, 3) != 0, $urandom_range(0, 2) != 0);
			end else if (pick < 90 && len < nais_pkg::ProgramDepth - 1) begin
				idx = $urandom_range(len + 1, nais_pkg::ProgramDepth - 1);
				send_item(nais_pkg::OP_BUF, rand_word(), $urandom(), 7'(idx / 8),
					3'(idx % 8), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (pick < 94) begin
				send_item(OpUnused, rand_word(), $urandom(), 7'($urandom()), 3'($urandom()),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				send_item(nais_pkg::OP_CTRL,
					$urandom_range(0, 1) ? nais_pkg::CTRL_START : rand_word(), $urandom(),
					7'($urandom()), 3'($urandom()), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		arst_n = 0; start = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
		opcode = '0; data_word = '0; start_mask = '0; buffer_column = '0;
		word_index = '0; mc_accept = 0; queues_empty = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(OpUnused, '1, '1, '1, '1, 1'b1, 1'b1);
		send_item(nais_pkg::OP_CTRL, 64'd2, '1, '0, '0, 1'b1, 1'b1);
		send_item(nais_pkg::OP_BUF, '1, '0, 7'd127, 3'd7, 1'b0, 1'b0);
		send_item(nais_pkg::OP_TICK, '0, '0, '0, '0, 1'b1, 1'b1);
		run_program(0);
		run_program(3);
		write_all_regs(18'd0, 3'd0, 2'd0, 4'd1, 3'd1);
		run_program(4);
		write_all_regs(18'h3FFFF, 3'd7, 2'd3, 4'd8, 3'd4);
		run_program(20);

		while (n_items < 650) begin
			if ($urandom_range(0, 2) == 0)
				write_all_regs(18'($urandom()), 3'($urandom()), 2'($urandom()),
					4'($urandom_range(1, 8)), 3'($urandom_range(1, 4)));
			run_program($urandom_range(0, 5) == 0 ? $urandom_range(13, 24) : $urandom_range(0, 12));
		end

		wait_idle();
		repeat (5) @(posedge clk);
		if (sb.errors == 0 && sb.exp_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
